@@ sv/gbs_pkg.sv @@
`default_nettype none

package gbs_pkg;

	// field widths
	localparam int COORD_W = 16;
	localparam int LABEL_W = 8;
	localparam int SLOT_W  = 8;
	localparam int AREA_W  = 32;
	localparam int LIMIT_W = 9;

	// shared multiplier operand and product widths
	localparam int MUL_A_W = AREA_W + 1;
	localparam int MUL_B_W = COORD_W;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = LIMIT_W;

	localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IOU_LIMIT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IOS_LIMIT      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLASS_AGNOSTIC = 2'd3;

	localparam logic MODE_IOU = 1'b0;
	localparam logic MODE_IOS = 1'b1;

	localparam logic [LIMIT_W-1:0] IOU_LIMIT_RST = 9'd115;
	localparam logic [LIMIT_W-1:0] IOS_LIMIT_RST = 9'd128;

	localparam int DEF_MAX_KEPT = 256;

	// one row of the kept table
	typedef struct packed {
		logic [AREA_W-1:0]  area;
		logic [LABEL_W-1:0] label;
		logic [COORD_W-1:0] h;
		logic [COORD_W-1:0] w;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} kept_entry_t;

endpackage

`default_nettype wire

@@ sv/gbs_if.sv @@
`default_nettype none

interface gbs_box_if
	import gbs_pkg::*;
();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] box_x;
	logic [COORD_W-1:0] box_y;
	logic [COORD_W-1:0] box_w;
	logic [COORD_W-1:0] box_h;
	logic [LABEL_W-1:0] class_label;
	logic               frame_end;

	modport source (
		output valid, box_x, box_y, box_w, box_h, class_label, frame_end,
		input  ready
	);
	modport sink (
		input  valid, box_x, box_y, box_w, box_h, class_label, frame_end,
		output ready
	);
endinterface

interface gbs_res_if
	import gbs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              keep;
	logic [SLOT_W-1:0] slot;
	logic              table_full;
	logic              frame_done;

	modport source (
		output valid, keep, slot, table_full, frame_done,
		input  ready
	);
	modport sink (
		input  valid, keep, slot, table_full, frame_done,
		output ready
	);
endinterface

`default_nettype wire

@@ sv/greedy_box_suppression.sv @@
// walk: each kept box of an eligible label takes the overlap, intersection, denominator,
//   limit and check steps, and any other box only the load and overlap steps; stops at a suppressor
// throughput: one box at a time, set by the walk of the kept table through one
//   shared multiplier and one table read port
// reset: arst_n clears the sequencer, the kept count and the output beat, and
//   restores register defaults; table contents are left as they are
`default_nettype none

module greedy_box_suppression
	import gbs_pkg::*;
#(
	parameter int MAX_KEPT = DEF_MAX_KEPT
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	gbs_box_if.sink                    box_in,
	gbs_res_if.source                  res_out
);

	// table address and kept count widths; count must hold MAX_KEPT itself
	localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CW = $clog2(MAX_KEPT + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_AREA,
		S_FIRST,
		S_LOAD,
		S_OVL,
		S_INTER,
		S_DENOM,
		S_LIMIT,
		S_CHECK,
		S_DECIDE
	} state_t;

	// overlap of two spans, edges 17 bits wide; never wider than either length
	function automatic logic [COORD_W-1:0] span_ovl(
		input logic [COORD_W-1:0] a0,
		input logic [COORD_W-1:0] alen,
		input logic [COORD_W-1:0] b0,
		input logic [COORD_W-1:0] blen
	);
		logic [COORD_W:0] a1;
		logic [COORD_W:0] b1;
		logic [COORD_W:0] lo;
		logic [COORD_W:0] hi;
		a1 = (COORD_W+1)'(a0) + (COORD_W+1)'(alen);
		b1 = (COORD_W+1)'(b0) + (COORD_W+1)'(blen);
		lo = (a0 > b0) ? (COORD_W+1)'(a0) : (COORD_W+1)'(b0);
		hi = (a1 < b1) ? a1 : b1;
		return (hi > lo) ? COORD_W'(hi - lo) : '0;
	endfunction

	// configuration registers
	logic               mode_q;
	logic [LIMIT_W-1:0] iou_limit_q;
	logic [LIMIT_W-1:0] ios_limit_q;
	logic               agnostic_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IOU;
			iou_limit_q <= IOU_LIMIT_RST;
			ios_limit_q <= IOS_LIMIT_RST;
			agnostic_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OVERLAP_MODE:   mode_q      <= cfg_data[0];
				CFG_IOU_LIMIT:      iou_limit_q <= cfg_data;
				CFG_IOS_LIMIT:      ios_limit_q <= cfg_data;
				CFG_CLASS_AGNOSTIC: agnostic_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer state and result beat
	state_t         state_q;
	logic [CW-1:0]  idx_q;
	logic [CW-1:0]  count_q;
	logic           keep_q;
	logic           res_valid_q;
	logic           res_keep_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic           res_full_q;
	logic           res_done_q;

	// latched box and walk datapath
	kept_entry_t        box_q;
	logic               fend_q;
	logic [AREA_W-1:0]  area_q;
	logic [COORD_W-1:0] ox_q;
	logic [COORD_W-1:0] oy_q;
	logic [AREA_W-1:0]  inter_q;
	logic [MUL_A_W-1:0] denom_q;

	kept_entry_t        rd_q;
	kept_entry_t        wr_data;
	logic               wr_en;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod_q;

	logic          in_fire;
	logic          can_emit;
	logic          is_ios;
	logic          eligible;
	logic          suppress;
	logic          full_now;
	logic          last_entry;
	logic [CW-1:0] idx_nxt;
	logic [AREA_W-1:0]  inter_now;
	logic [MUL_A_W-1:0] union_now;
	logic [MUL_A_W-1:0] small_now;

	assign box_in.ready = (state_q == S_IDLE);
	assign in_fire      = box_in.valid && box_in.ready;
	assign can_emit     = !res_valid_q || res_out.ready;

	assign is_ios     = (mode_q == MODE_IOS);
	// label must match unless agnostic iou mode
	assign eligible   = !(is_ios || !agnostic_q) || (rd_q.label == box_q.label);
	assign idx_nxt    = idx_q + CW'(1);
	assign last_entry = (idx_nxt >= count_q);
	assign full_now   = (count_q >= CW'(MAX_KEPT));

	// intersection comes out of the multiplier during the denominator step
	assign inter_now = prod_q[AREA_W-1:0];
	// union never goes below the intersection, so no wrap
	assign union_now = MUL_A_W'(area_q) + MUL_A_W'(rd_q.area) - MUL_A_W'(inter_now);
	assign small_now = (area_q < rd_q.area) ? MUL_A_W'(area_q) : MUL_A_W'(rd_q.area);

	// inter * 256 > limit * denom, with a zero denominator never suppressing
	assign suppress = (denom_q != '0)
		&& ({{(MUL_P_W - AREA_W - 8){1'b0}}, inter_q, 8'd0} > prod_q);

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_AREA: begin
				mul_a = MUL_A_W'(box_q.w);
				mul_b = box_q.h;
			end
			S_INTER: begin
				mul_a = MUL_A_W'(ox_q);
				mul_b = oy_q;
			end
			S_LIMIT: begin
				mul_a = denom_q;
				mul_b = MUL_B_W'(is_ios ? ios_limit_q : iou_limit_q);
			end
			default: ;
		endcase
	end

	// surviving box goes into the next free row
	always_comb begin
		wr_en        = (state_q == S_DECIDE) && can_emit && keep_q && !full_now;
		wr_data      = box_q;
		wr_data.area = area_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			count_q     <= '0;
			keep_q      <= 1'b1;
			res_valid_q <= 1'b0;
			res_keep_q  <= 1'b0;
			res_slot_q  <= '0;
			res_full_q  <= 1'b0;
			res_done_q  <= 1'b0;
		end else begin
			if (res_valid_q && res_out.ready && state_q != S_DECIDE) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						idx_q   <= '0;
						keep_q  <= 1'b1;
						state_q <= S_AREA;
					end
				end
				// row 0 read and own area product both land in S_FIRST
				S_AREA: state_q <= S_FIRST;
				S_FIRST: state_q <= (count_q == '0) ? S_DECIDE : S_OVL;
				S_LOAD: state_q <= S_OVL;
				S_OVL: begin
					if (eligible) begin
						state_q <= S_INTER;
					end else if (last_entry) begin
						state_q <= S_DECIDE;
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_LOAD;
					end
				end
				S_INTER: state_q <= S_DENOM;
				S_DENOM: state_q <= S_LIMIT;
				S_LIMIT: state_q <= S_CHECK;
				S_CHECK: begin
					if (suppress) begin
						// one suppressing box settles it
						keep_q  <= 1'b0;
						state_q <= S_DECIDE;
					end else if (last_entry) begin
						state_q <= S_DECIDE;
					end else begin
						idx_q   <= idx_nxt;
						state_q <= S_LOAD;
					end
				end
				S_DECIDE: begin
					if (can_emit) begin
						res_valid_q <= 1'b1;
						res_keep_q  <= keep_q;
						res_full_q  <= keep_q && full_now;
						res_slot_q  <= wr_en ? SLOT_W'(count_q) : '0;
						res_done_q  <= fend_q;
						if (fend_q) begin
							count_q <= '0;
						end else if (wr_en) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire) begin
			box_q.x     <= box_in.box_x;
			box_q.y     <= box_in.box_y;
			box_q.w     <= box_in.box_w;
			box_q.h     <= box_in.box_h;
			box_q.label <= box_in.class_label;
			box_q.area  <= '0;
			fend_q      <= box_in.frame_end;
		end
		if (state_q == S_FIRST) begin
			area_q <= prod_q[AREA_W-1:0];
		end
		if (state_q == S_OVL) begin
			ox_q <= span_ovl(box_q.x, box_q.w, rd_q.x, rd_q.w);
			oy_q <= span_ovl(box_q.y, box_q.h, rd_q.y, rd_q.h);
		end
		if (state_q == S_DENOM) begin
			inter_q <= inter_now;
			denom_q <= is_ios ? small_now : union_now;
		end
	end

	gbs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	gbs_table #(
		.DEPTH (MAX_KEPT),
		.AW    (AW)
	) u_table (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (count_q[AW-1:0]),
		.wdata   (wr_data),
		.raddr   (idx_q[AW-1:0]),
		.rdata_q (rd_q)
	);

	// result beat
	assign res_out.valid      = res_valid_q;
	assign res_out.keep       = res_keep_q;
	assign res_out.slot       = res_slot_q;
	assign res_out.table_full = res_full_q;
	assign res_out.frame_done = res_done_q;

endmodule

`default_nettype wire

@@ sv/gbs_mul.sv @@
`default_nettype none

// shared multiplier, product registered
module gbs_mul
	import gbs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic [MUL_A_W-1:0] a,
	input  wire logic [MUL_B_W-1:0] b,
	output logic      [MUL_P_W-1:0] p_q
);

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

endmodule

`default_nettype wire

@@ sv/gbs_table.sv @@
`default_nettype none

// kept box table, one write and one registered read per cycle
module gbs_table
	import gbs_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_KEPT,
	parameter int AW    = 8
) (
	input  wire logic        clk,
	input  wire logic        we,
	input  wire logic [AW-1:0] waddr,
	input  wire kept_entry_t wdata,
	input  wire logic [AW-1:0] raddr,
	output kept_entry_t      rdata_q
);

	kept_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

`default_nettype wire

@@ sv/gbs_checker.sv @@
`default_nettype none

module gbs_checker
	import gbs_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic              keep,
	input wire logic [SLOT_W-1:0] slot,
	input wire logic              table_full,
	input wire logic              frame_done
);

	// a held result beat does not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(keep) && $stable(slot)
			&& $stable(table_full) && $stable(frame_done))
		else $error("result beat changed while stalled");

	// a dropped box has no slot and no full flag
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !keep |-> slot == '0 && !table_full)
		else $error("dropped box carries slot or full flag");

	// full flag only on a surviving box that was not stored
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> keep && slot == '0)
		else $error("full flag on wrong result");

	// one box at a time: no accept in the cycle after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while walking table");

endmodule

bind greedy_box_suppression gbs_checker u_gbs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (box_in.valid),
	.in_ready   (box_in.ready),
	.out_valid  (res_out.valid),
	.out_ready  (res_out.ready),
	.keep       (res_out.keep),
	.slot       (res_out.slot),
	.table_full (res_out.table_full),
	.frame_done (res_out.frame_done)
);

`default_nettype wire
